// ===== rtl/iest_pkg.sv =====
// Shared types and constants for the input edge stop trigger.
`timescale 1ns / 1ps
`default_nettype none

package iest_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned MaskW     = 6;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned DecelW    = 16;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 24;

  localparam logic [TimeW-1:0]  DebounceReset = TimeW'(200);
  localparam logic [DecelW-1:0] DecelReset    = 16'hFFFF;

  // action mask bit positions
  localparam int unsigned ActStopRise  = 0;
  localparam int unsigned ActStopFall  = 1;
  localparam int unsigned ActBrakeRise = 2;
  localparam int unsigned ActBrakeFall = 3;
  localparam int unsigned ActCbRise    = 4;
  localparam int unsigned ActCbFall    = 5;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdTick   = 1'b1
  } cmd_e;

  // register index bits [2:1] select the register kind, bit 0 the channel
  typedef enum logic [1:0] {
    CfgMask     = 2'd0,
    CfgDebounce = 2'd1,
    CfgDecel    = 2'd2
  } cfg_kind_e;

  typedef struct packed {
    logic [MaskW-1:0]  mask;
    logic [TimeW-1:0]  debounce;
    logic [DecelW-1:0] decel;
  } chan_cfg_t;

  typedef struct packed {
    logic level;
    logic edge_hit;
    logic cb;
    logic brake;
    logic stop;
  } chan_res_t;

endpackage

`default_nettype wire

// ===== rtl/iest_cfg.sv =====
// Configuration register file: action masks, debounce times and stop decelerations.
`timescale 1ns / 1ps
`default_nettype none

module iest_cfg #(
  parameter int unsigned CHANNELS = 2
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              we_i,
  input  wire  [iest_pkg::CfgIdxW-1:0]     index_i,
  input  wire  [iest_pkg::CfgDataW-1:0]    data_i,
  output iest_pkg::chan_cfg_t              cfg_o [CHANNELS]
);
  import iest_pkg::*;

  cfg_kind_e kind;
  assign kind = cfg_kind_e'(index_i[CfgIdxW-1:1]);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    if (c < 2) begin : g_reg
      chan_cfg_t cfg_q, cfg_d;
      logic      sel;

      assign sel = we_i && (index_i[0] == 1'(c));

      always_comb begin
        cfg_d = cfg_q;
        if (sel) begin
          unique case (kind)
            CfgMask:     cfg_d.mask     = data_i[MaskW-1:0];
            CfgDebounce: cfg_d.debounce = data_i[TimeW-1:0];
            CfgDecel:    cfg_d.decel    = data_i[DecelW-1:0];
            default:     cfg_d          = cfg_q;
          endcase
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cfg_q.mask     <= '0;
          cfg_q.debounce <= DebounceReset;
          cfg_q.decel    <= DecelReset;
        end else begin
          cfg_q <= cfg_d;
        end
      end

      assign cfg_o[c] = cfg_q;
    end else begin : g_fixed
      // channels past the register map keep reset values
      assign cfg_o[c] = '{mask: '0, debounce: DebounceReset, decel: DecelReset};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iest_chan.sv =====
// One channel: stored level, lockout counter and edge action decode.
`timescale 1ns / 1ps
`default_nettype none

module iest_chan (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  adv_i,
  input  wire                  tick_i,
  input  wire                  pin_i,
  input  wire iest_pkg::chan_cfg_t cfg_i,
  output iest_pkg::chan_res_t  res_o
);
  import iest_pkg::*;

  logic             level_q, level_d;
  logic [TimeW-1:0] lock_q, lock_d;
  logic             take;
  logic             brake_bit, stop_bit, cb_bit;

  assign take = !tick_i && (pin_i != level_q) && (lock_q == '0);

  always_comb begin
    level_d = level_q;
    lock_d  = lock_q;
    if (tick_i) begin
      if (lock_q != '0) lock_d = lock_q - TimeW'(1);
    end else if (take) begin
      level_d = pin_i;
      // a zero debounce time loads zero, so no lockout runs
      lock_d  = cfg_i.debounce;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      lock_q  <= '0;
    end else if (adv_i) begin
      level_q <= level_d;
      lock_q  <= lock_d;
    end
  end

  assign brake_bit = pin_i ? cfg_i.mask[ActBrakeRise] : cfg_i.mask[ActBrakeFall];
  assign stop_bit  = pin_i ? cfg_i.mask[ActStopRise]  : cfg_i.mask[ActStopFall];
  assign cb_bit    = pin_i ? cfg_i.mask[ActCbRise]    : cfg_i.mask[ActCbFall];

  assign res_o.level    = level_d;
  assign res_o.edge_hit = take;
  assign res_o.cb       = take && cb_bit;
  assign res_o.brake    = take && brake_bit;
  assign res_o.stop     = take && !brake_bit && stop_bit;

endmodule

`default_nettype wire

// ===== rtl/input_edge_stop_trigger.sv =====
// Top level: input register, channel logic, request merge and result register.
//
//  channel  | direction | fields (low bit first)
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tdata: pin_levels[1:0], pad; tuser: command
//  m_axis   | out       | tdata: accepted_levels, edge_taken, callback_event,
//           |           |        brake_request, stop_request, stop_decel[15:0], pad
//  cfg      | in        | cfg_index_i (register 0..5), cfg_data_i
//
// One word per cycle sustained while the result register drains; an accepted word
// passes from the input register through the channel logic into the result register.
// Reset clears levels and lockouts and loads the register reset values.
// A stalled result holds; the input register still takes a word when the
// result register drains in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module input_edge_stop_trigger #(
  parameter int unsigned CHANNELS = 2
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [iest_pkg::InDataW-1:0]      s_axis_tdata,   // pin_levels[1:0], zero pad
  input  wire                               s_axis_tuser,   // command
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [iest_pkg::OutDataW-1:0]     m_axis_tdata,   // levels, edges, cb, brake,
                                                            // stop, stop_decel, pad
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [iest_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [iest_pkg::CfgDataW-1:0]     cfg_data_i
);
  import iest_pkg::*;

  chan_cfg_t cfg [CHANNELS];
  chan_res_t res [CHANNELS];

  logic                in_valid_q;
  cmd_e                in_cmd_q;
  logic [1:0]          in_pin_q;
  logic                adv;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [CHANNELS-1:0] pin_vec;
  logic [1:0]          levels, edges;
  logic                cb_any, brake_any, stop_any;
  logic [DecelW-1:0]   decel_sel;

  assign cfg_ready_o = 1'b1;

  iest_cfg #(.CHANNELS(CHANNELS)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // advance the input word into the result register
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q <= cmd_e'(s_axis_tuser);
      in_pin_q <= s_axis_tdata[1:0];
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    if (c < 2) begin : g_pin
      assign pin_vec[c] = in_pin_q[c];
    end else begin : g_nopin
      assign pin_vec[c] = 1'b0;
    end

    iest_chan u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tick_i (in_cmd_q == CmdTick),
      .pin_i  (pin_vec[c]),
      .cfg_i  (cfg[c]),
      .res_o  (res[c])
    );
  end

  for (genvar c = 0; c < 2; c++) begin : g_show
    if (c < CHANNELS) begin : g_on
      assign levels[c] = res[c].level;
      assign edges[c]  = res[c].edge_hit;
    end else begin : g_off
      assign levels[c] = 1'b0;
      assign edges[c]  = 1'b0;
    end
  end

  // higher channel overrides lower for the stop deceleration
  always_comb begin
    cb_any    = 1'b0;
    brake_any = 1'b0;
    stop_any  = 1'b0;
    decel_sel = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      cb_any    = cb_any | res[c].cb;
      brake_any = brake_any | res[c].brake;
      if (res[c].stop) begin
        stop_any  = 1'b1;
        decel_sel = cfg[c].decel;
      end
    end
    // any brake drops the stop
    if (brake_any) begin
      stop_any  = 1'b0;
      decel_sel = '0;
    end
  end

  assign out_data_d  = {1'b0, decel_sel, stop_any, brake_any, cb_any, edges, levels};
  assign out_valid_d = adv ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_no_brake_and_stop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[5] && m_axis_tdata[6]))
    else $error("brake and stop requested together");

  a_decel_only_with_stop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[6]) |-> (m_axis_tdata[22:7] == '0))
    else $error("deceleration without stop request");

  a_tick_no_edges : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_cmd_q == CmdTick)) |=> (m_axis_tdata[6:2] == '0))
    else $error("tick word produced an edge or request");

  a_edge_changes_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res[0].edge_hit) |=> (m_axis_tdata[0] != $past(g_ch[0].u_chan.level_q)))
    else $error("taken edge left level unchanged");

endmodule

`default_nettype wire

// ===== bench/input_edge_stop_trigger_tb.sv =====
// Testbench for the input edge stop trigger: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module input_edge_stop_trigger_tb;
  import iest_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned LongHold    = 50;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned PhaseWords  = 100;

  localparam logic [CfgIdxW-1:0] RegMask0     = {CfgMask, 1'b0};
  localparam logic [CfgIdxW-1:0] RegMask1     = {CfgMask, 1'b1};
  localparam logic [CfgIdxW-1:0] RegDebounce0 = {CfgDebounce, 1'b0};
  localparam logic [CfgIdxW-1:0] RegDebounce1 = {CfgDebounce, 1'b1};
  localparam logic [CfgIdxW-1:0] RegDecel0    = {CfgDecel, 1'b0};
  localparam logic [CfgIdxW-1:0] RegDecel1    = {CfgDecel, 1'b1};
  localparam logic [CfgIdxW-1:0] RegUnusedLo  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi  = 3'd7;

  localparam logic [MaskW-1:0] StopRise  = MaskW'(1) << ActStopRise;
  localparam logic [MaskW-1:0] StopFall  = MaskW'(1) << ActStopFall;
  localparam logic [MaskW-1:0] BrakeRise = MaskW'(1) << ActBrakeRise;
  localparam logic [MaskW-1:0] BrakeFall = MaskW'(1) << ActBrakeFall;
  localparam logic [MaskW-1:0] CbRise    = MaskW'(1) << ActCbRise;
  localparam logic [MaskW-1:0] CbFall    = MaskW'(1) << ActCbFall;

  // result word, lowest field last
  typedef struct packed {
    logic [DecelW-1:0] decel;
    logic              stop;
    logic              brake;
    logic              cb;
    logic [1:0]        edges;
    logic [1:0]        levels;
  } out_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // predictor copy of registers and channel state
  logic [MaskW-1:0]  act_mask   [2] = '{default: '0};
  logic [TimeW-1:0]  debounce_q [2] = '{default: DebounceReset};
  logic [DecelW-1:0] decel_q    [2] = '{default: DecelReset};
  logic [1:0]        level_q        = '0;
  logic [TimeW-1:0]  lockout_q  [2] = '{default: '0};

  out_word_t   qualified_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  logic        src_idle    = 1'b0;
  logic        sink_idle   = 1'b0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned sink_wait   = 0;

  input_edge_stop_trigger dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void apply_cfg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    int ch;
    ch = int'(idx[0]);
    case (cfg_kind_e'(idx[2:1]))
      CfgMask:     act_mask[ch]   = val[MaskW-1:0];
      CfgDebounce: debounce_q[ch] = val[TimeW-1:0];
      CfgDecel:    decel_q[ch]    = val[DecelW-1:0];
      default: ;  // unused index: drop the write
    endcase
  endfunction

  function automatic out_word_t qualify_item(input cmd_e cmd, input logic [1:0] pins);
    out_word_t        w;
    logic             v;
    logic [MaskW-1:0] a;
    w = '0;
    if (cmd == CmdTick) begin
      for (int c = 0; c < 2; c++)
        if (lockout_q[c] != 0) lockout_q[c] = lockout_q[c] - 1'b1;
    end else begin
      for (int c = 0; c < 2; c++) begin
        v = pins[c];
        a = act_mask[c];
        if (v != level_q[c] && lockout_q[c] == 0) begin
          level_q[c]  = v;
          w.edges[c] = 1'b1;
          if (debounce_q[c] != 0) lockout_q[c] = debounce_q[c];
          if (v ? a[ActCbRise] : a[ActCbFall]) w.cb = 1'b1;
          if (v ? a[ActBrakeRise] : a[ActBrakeFall]) begin
            w.brake = 1'b1;
          end else if (v ? a[ActStopRise] : a[ActStopFall]) begin
            w.stop  = 1'b1;
            w.decel = decel_q[c];
          end
        end
      end
    end
    // any brake wins over every stop
    if (w.brake) begin
      w.stop  = 1'b0;
      w.decel = '0;
    end
    w.levels = level_q;
    return w;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("mismatch %0d at cycle %0d: %s expected %0h got %0h",
               mismatch_count, cycle_count, what, want, got);
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) note_mismatch(what, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    out_word_t got;
    out_word_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = out_word_t'(m_axis_tdata[$bits(out_word_t)-1:0]);
      if (qualified_q.size() == 0) begin
        note_mismatch("word with nothing expected", 0, 32'(got));
      end else begin
        want = qualified_q.pop_front();
        check_field("accepted_levels", 32'(want.levels), 32'(got.levels));
        check_field("edge_taken", 32'(want.edges), 32'(got.edges));
        check_field("callback_event", 32'(want.cb), 32'(got.cb));
        check_field("brake_request", 32'(want.brake), 32'(got.brake));
        check_field("stop_request", 32'(want.stop), 32'(got.stop));
        check_field("stop_decel", 32'(want.decel), 32'(got.decel));
      end
    end
  end

  // long receiver hold, started by flipping hold_toggle
  always @(posedge clk_i) begin : long_hold
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LongHold;
    end
  end

  always @(posedge clk_i) begin : result_sink
    int unsigned wait_n;
    wait_n = sink_wait;
    if (m_axis_tvalid && m_axis_tready)
      wait_n = sink_idle ? $urandom_range(0, 3) : 0;
    else if (wait_n != 0)
      wait_n--;
    sink_wait     <= wait_n;
    m_axis_tready <= rst_ni && wait_n == 0 && hold_left == 0;
  end

  // call at a rising edge; returns at the edge that takes the word
  task automatic send_word(input cmd_e cmd, input logic [1:0] pins);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(pins);
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    qualified_q.push_back(qualify_item(cmd, pins));
  endtask

  task automatic send_random_word();
    if ($urandom_range(0, 9) < 4)
      send_word(CmdTick, 2'($urandom_range(0, 3)));
    else
      send_word(CmdSample, 2'($urandom_range(0, 3)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (qualified_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_cfg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [MaskW-1:0] m0, input logic [MaskW-1:0] m1,
                           input logic [TimeW-1:0] d0, input logic [TimeW-1:0] d1,
                           input logic [DecelW-1:0] s0, input logic [DecelW-1:0] s1);
    write_reg(RegMask0, CfgDataW'(m0));
    write_reg(RegMask1, CfgDataW'(m1));
    write_reg(RegDebounce0, d0);
    write_reg(RegDebounce1, d1);
    write_reg(RegDecel0, s0);
    write_reg(RegDecel1, s1);
  endtask

  // reset debounce and decel are still in place; only the channel 0 mask changes
  task automatic test_reset_values();
    write_reg(RegMask0, CfgDataW'(StopRise | StopFall));
    send_word(CmdSample, 2'b01);
    send_word(CmdSample, 2'b00);
    send_word(CmdTick, 2'b11);
    send_word(CmdSample, 2'b10);
    drain();
  endtask

  task automatic test_actions();
    write_reg(RegUnusedLo, 16'hFFFF);
    write_reg(RegUnusedHi, 16'hFFFF);
    configure(6'h3F, StopRise | StopFall | CbFall, 16'd0, 16'd0, 16'h0000, 16'hFFFF);
    send_word(CmdSample, 2'b01);  // ch1 fall: still locked out from the reset-value test, no edge
    send_word(CmdSample, 2'b11);  // both pins match the stored levels: no edge
    send_word(CmdSample, 2'b00);  // both fall: both lockouts still running, no edge
    send_word(CmdSample, 2'b10);
    drain();
    configure(StopRise | StopFall | CbRise, StopRise | BrakeFall, 16'd0, 16'd0,
              16'hFFFF, 16'h0000);
    send_word(CmdSample, 2'b11);  // both pins match the stored levels: no edge
    send_word(CmdSample, 2'b01);  // ch1 fall: still locked out, no edge
    send_word(CmdSample, 2'b00);  // ch0 fall: still locked out, no edge
    send_word(CmdSample, 2'b01);
    drain();
  endtask

  task automatic test_lockout();
    configure(StopFall | CbRise, BrakeRise, 16'd2, 16'd0, 16'h5A5A, 16'hA5A5);
    send_word(CmdSample, 2'b00);
    send_word(CmdSample, 2'b01);
    send_word(CmdTick, 2'b10);
    send_word(CmdSample, 2'b00);
    send_word(CmdTick, 2'b00);
    send_word(CmdSample, 2'b10);
    send_word(CmdTick, 2'b01);
    send_word(CmdTick, 2'b11);
    send_word(CmdSample, 2'b00);
    drain();
  endtask

  task automatic test_backpressure();
    configure(6'h3F, StopRise | CbFall, 16'd0, 16'd1, 16'h1234, 16'h4321);
    src_idle    <= 1'b0;
    sink_idle   <= 1'b0;
    hold_toggle <= ~hold_toggle;
    repeat (40) send_random_word();
    drain();
    src_idle  <= 1'b1;
    sink_idle <= 1'b1;
    hold_toggle <= ~hold_toggle;
    repeat (40) send_random_word();
    drain();
  endtask

  task automatic test_random();
    logic [MaskW-1:0]  m;
    logic [TimeW-1:0]  d;
    logic [DecelW-1:0] s;
    for (int p = 0; p < RandPhases; p++) begin
      for (int c = 0; c < 2; c++) begin
        if (p == 0)      m = '1;
        else if (p == 1) m = '0;
        else             m = MaskW'($urandom_range(0, 63));
        // long lockouts only in the last phase so earlier phases keep taking edges
        if (p == RandPhases - 1) d = (c == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        else                     d = 16'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0:       s = '0;
          1:       s = '1;
          default: s = 16'($urandom_range(0, 65535));
        endcase
        write_reg({CfgMask, c[0]}, CfgDataW'(m));
        write_reg({CfgDebounce, c[0]}, d);
        write_reg({CfgDecel, c[0]}, s);
      end
      src_idle  <= (p % 3) != 0;
      sink_idle <= (p % 3) != 1;
      @(posedge clk_i);
      repeat (PhaseWords) send_random_word();
      drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_actions();
    test_lockout();
    test_backpressure();
    test_random();
    drain();
    if (mismatch_count == 0 && qualified_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
